FILE: src/scx_pkg.sv
package scx_pkg;

  // Channel and buffer geometry.
  localparam int CHANNELS = 9;
  localparam int MAX_LEN = 32;

  // Field widths of the transactions.
  localparam int CH_W = 4;
  localparam int BYTE_W = 8;
  localparam int STATUS_W = 3;
  localparam int TLEN_W = 6;
  localparam int CFG_IDX_W = 2;

  // Widths derived from the geometry.
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int STORE_DEPTH = CHANNELS * MAX_LEN;
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // Queue between the front and the back part.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRITE_ALLOWED = 2'd0,
    CFG_START_CODE    = 2'd1,
    CFG_END_CODE      = 2'd2
  } cfg_index_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_STORED      = 3'd0,
    ST_STARTED     = 3'd1,
    ST_COMPLETED   = 3'd2,
    ST_REJECTED    = 3'd3,
    ST_BAD_CHANNEL = 3'd4,
    ST_DROPPED     = 3'd5
  } status_t;

  // Classification made by the front part.
  typedef enum logic [2:0] {
    KIND_REJECT,
    KIND_BAD,
    KIND_START,
    KIND_END,
    KIND_DATA
  } kind_t;

  // One classified byte waiting in the queue.
  typedef struct packed {
    kind_t              kind;
    logic [CH_W-1:0]    channel;
    logic [BYTE_W-1:0]  data_byte;
    logic               packet_end;
  } entry_t;

endpackage

FILE: src/scx_in_if.sv
interface scx_in_if;
  logic                         valid;
  logic                         ready;
  logic [scx_pkg::CH_W-1:0]     channel;
  logic [scx_pkg::BYTE_W-1:0]   data_byte;
  logic                         packet_end;

  modport source(output valid, output channel, output data_byte, output packet_end,
                 input ready);
  modport sink(input valid, input channel, input data_byte, input packet_end,
               output ready);
endinterface

FILE: src/scx_out_if.sv
interface scx_out_if;
  logic                         valid;
  logic                         ready;
  scx_pkg::status_t             status;
  logic [scx_pkg::CH_W-1:0]     channel_out;
  logic [scx_pkg::TLEN_W-1:0]   text_length;
  logic                         text_changed;
  logic                         display_update;
  logic                         packet_end_out;

  modport source(output valid, output status, output channel_out, output text_length,
                 output text_changed, output display_update, output packet_end_out,
                 input ready);
  modport sink(input valid, input status, input channel_out, input text_length,
               input text_changed, input display_update, input packet_end_out,
               output ready);
endinterface

FILE: src/scx_cfg_if.sv
interface scx_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [scx_pkg::CFG_IDX_W-1:0]    index;
  logic [scx_pkg::BYTE_W-1:0]       data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

FILE: src/scx_front.sv
module scx_front (
  input  logic            clk,
  input  logic            rst,
  scx_in_if.sink          bytes,
  scx_cfg_if.sink         cfg,
  output logic            push_valid,
  input  logic            push_ready,
  output scx_pkg::entry_t push_entry
);
  import scx_pkg::*;

  logic              write_allowed;
  logic [BYTE_W-1:0] start_code;
  logic [BYTE_W-1:0] end_code;
  logic              bad_channel;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_allowed <= 1'b0;
      start_code    <= 8'd2;
      end_code      <= 8'd3;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_WRITE_ALLOWED: write_allowed <= cfg.data[0];
        CFG_START_CODE:    start_code    <= cfg.data;
        CFG_END_CODE:      end_code      <= cfg.data;
        default: ;
      endcase
    end
  end

  // Channel numbers at or above the channel count are invalid.
  assign bad_channel = {1'b0, bytes.channel} >= (CH_W + 1)'(CHANNELS);

  // Classify the byte; a start code wins over an equal end code.
  always_comb begin
    push_entry.channel    = bytes.channel;
    push_entry.data_byte  = bytes.data_byte;
    push_entry.packet_end = bytes.packet_end;
    if (!write_allowed) begin
      push_entry.kind = KIND_REJECT;
    end else if (bad_channel) begin
      push_entry.kind = KIND_BAD;
    end else if (bytes.data_byte == start_code) begin
      push_entry.kind = KIND_START;
    end else if (bytes.data_byte == end_code) begin
      push_entry.kind = KIND_END;
    end else begin
      push_entry.kind = KIND_DATA;
    end
  end

  assign push_valid  = bytes.valid;
  assign bytes.ready = push_ready;

endmodule

FILE: src/scx_queue.sv
module scx_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  scx_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop_ready,
  output scx_pkg::entry_t pop_entry
);
  import scx_pkg::*;

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count < QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: src/scx_back.sv
module scx_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  scx_pkg::entry_t pop_entry,
  scx_out_if.source       results
);
  import scx_pkg::*;

  // Item between the issue stage and the compare stage.
  typedef struct packed {
    status_t             status;
    logic [CH_W-1:0]     channel;
    logic [CH_IDX_W-1:0] ch_idx;
    logic [LEN_W-1:0]    len;
    logic                old_valid;
    logic [BYTE_W-1:0]   data_byte;
    logic                packet_end;
  } stage_t;

  // Per-channel state. The high-water mark tells which entries were ever
  // written; entries at or above it read zero, so the store needs no reset.
  logic [LEN_W-1:0]   fill_count [CHANNELS];
  logic [LEN_W-1:0]   high_water [CHANNELS];
  logic               changed    [CHANNELS];
  logic [BYTE_W-1:0]  text_mem   [STORE_DEPTH];
  logic [BYTE_W-1:0]  rd_data;

  logic                issue;
  logic [CH_IDX_W-1:0] ci;
  logic [LEN_W-1:0]    cnt;
  logic                full;
  logic                store;
  logic [ADDR_W-1:0]   addr;
  stage_t              s1;

  stage_t              b2;
  logic                b2_valid;
  logic                b2_adv;
  logic                flag;
  logic [BYTE_W-1:0]   old_byte;
  logic                chg;
  logic                disp;
  logic                out_valid;

  // Issue stage: read-modify-write of the count and the text store.
  assign ci    = pop_entry.channel[CH_IDX_W-1:0];
  assign cnt   = fill_count[ci];
  assign full  = cnt >= LEN_W'(MAX_LEN);
  assign store = (pop_entry.kind == KIND_DATA) && !full;
  assign addr  = ADDR_W'(ci) * ADDR_W'(MAX_LEN) + ADDR_W'(cnt[POS_W-1:0]);

  assign b2_adv    = b2_valid && (!out_valid || results.ready);
  assign issue     = pop_valid && (!b2_valid || b2_adv);
  assign pop_ready = !b2_valid || b2_adv;

  always_comb begin
    s1.channel    = pop_entry.channel;
    s1.ch_idx     = ci;
    s1.data_byte  = pop_entry.data_byte;
    s1.packet_end = pop_entry.packet_end;
    s1.old_valid  = cnt < high_water[ci];
    s1.len        = cnt;
    case (pop_entry.kind)
      KIND_REJECT: begin
        s1.status = ST_REJECTED;
        s1.len    = '0;
      end
      KIND_BAD: begin
        s1.status = ST_BAD_CHANNEL;
        s1.len    = '0;
      end
      KIND_START: begin
        s1.status = ST_STARTED;
        s1.len    = '0;
      end
      KIND_END: begin
        s1.status = ST_COMPLETED;
      end
      default: begin
        if (full) begin
          s1.status = ST_DROPPED;
        end else begin
          s1.status = ST_STORED;
          s1.len    = cnt + 1'b1;
        end
      end
    endcase
  end

  // Counts and marks move at issue so the next byte of the channel sees them.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fill_count[i] <= '0;
        high_water[i] <= '0;
      end
    end else if (issue) begin
      if (pop_entry.kind == KIND_START) begin
        fill_count[ci] <= '0;
      end else if (store) begin
        fill_count[ci] <= cnt + 1'b1;
        if (cnt == high_water[ci]) begin
          high_water[ci] <= high_water[ci] + 1'b1;
        end
      end
    end
  end

  // Text store: the old byte is read while the new one is written.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= text_mem[addr];
      if (store) begin
        text_mem[addr] <= pop_entry.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (issue) begin
      b2_valid <= 1'b1;
    end else if (b2_adv) begin
      b2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b2 <= s1;
    end
  end

  // Compare stage: changed flags are updated in item order here.
  assign flag     = changed[b2.ch_idx];
  assign old_byte = b2.old_valid ? rd_data : '0;

  always_comb begin
    chg  = 1'b0;
    disp = 1'b0;
    case (b2.status)
      ST_STORED:    chg = flag || (old_byte != b2.data_byte);
      ST_STARTED:   chg = 1'b0;
      ST_COMPLETED: begin
        chg  = flag;
        disp = flag;
      end
      ST_DROPPED:   chg = flag;
      default:      chg = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        changed[i] <= 1'b0;
      end
    end else if (b2_adv && (b2.status == ST_STORED || b2.status == ST_STARTED)) begin
      changed[b2.ch_idx] <= chg;
    end
  end

  // Output register; it holds its transaction until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b2_adv) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_adv) begin
      results.status         <= b2.status;
      results.channel_out    <= b2.channel;
      results.text_length    <= TLEN_W'(b2.len);
      results.text_changed   <= chg;
      results.display_update <= disp;
      results.packet_end_out <= b2.packet_end;
    end
  end

  assign results.valid = out_valid;

`ifndef SYNTHESIS
  // A stalled compare stage keeps its item.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    b2_valid && !b2_adv |=> b2_valid && $stable(b2))
    else $error("compare stage item changed while stalled");

  // A fill count never passes the buffer length.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    b2_valid |-> b2.len <= LEN_W'(MAX_LEN))
    else $error("fill count beyond buffer length");

  // Rejected and bad-channel results carry no length and no flags.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    b2_adv && (b2.status == ST_REJECTED || b2.status == ST_BAD_CHANNEL)
    |=> results.text_length == '0 && !results.text_changed && !results.display_update)
    else $error("rejected result carries state");

  // A display update only comes with a completed frame.
  a_disp_completed: assert property (@(posedge clk) disable iff (rst)
    out_valid && results.display_update |-> results.status == ST_COMPLETED)
    else $error("display update on a result that is not a completion");
`endif

endmodule

FILE: src/multichannel_stx_etx_string_collector_top.sv
// Multichannel start/end framed text collector.
// The bytes channel carries one byte per transaction, tagged with a channel
// number. Each channel has its own text buffer, fill count and changed flag.
// A start code clears the count and flag, an end code reports the frame
// length and asks for a display update when the stored text changed, and any
// other byte overwrites the buffer at the count unless the buffer is full.
// The results channel returns exactly one transaction per byte, in order.
// The cfg channel writes write_allowed (index 0), start_code (1) and
// end_code (2); it is always ready. The user must write it only while the
// block idles; the block itself does not enforce this. Throughput is one
// byte per cycle while the receiver takes results, set by the single
// read-modify-write of the text store memory in the back part.
// A two-entry queue separates classification from the store update, and an
// output register holds each result; when the receiver stalls, the output
// register, the compare stage and then the queue fill before bytes.ready
// drops. Reset clears all counts and flags, resets configuration at once;
// buffer contents read as zero until written, so no clearing pass is needed.
module multichannel_stx_etx_string_collector_top (
  input  logic      clk,
  input  logic      rst,
  scx_in_if.sink    bytes,
  scx_cfg_if.sink   cfg,
  scx_out_if.source results
);
  import scx_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  scx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  scx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  scx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .results   (results)
  );

endmodule
